/* design/cfd_pkg.sv */
// Shared types, constants and the CRC-16/CCITT-FALSE byte step for the deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int LEN_W = 7;   // payload length, 0..127
    localparam int IDX_W = 6;   // byte position, 0..63

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] STAT_GOOD     = 2'd0;
    localparam logic [1:0] STAT_CRC_ERR  = 2'd1;
    localparam logic [1:0] STAT_OVERSIZE = 2'd2;

    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_MAX_LEN    = 1'b1;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } t_drain_ctl;

    typedef struct packed {
        logic             busy;
        logic             valid;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_drain_stat;

    // One byte through the MSB-first CRC register, no reflection.
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (v[15]) begin
                v = {v[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[14:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

/* design/cfd_drain.sv */
// Payload store and readout sequencer of the deframer.
// Holds the synchronous payload memory; depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_drain
    import cfd_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [7:0]                          i_wr_data,
    input  t_drain_ctl                          i_ctl,
    input  logic                                i_take,
    output t_drain_stat                         o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_q;
    logic [IDX_W-1:0] r_q_idx;
    logic             r_active;
    logic             r_rd_pend;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_rd_idx;

    logic issue_left;
    logic rd_en;
    logic done;
    logic n_rd_pend;

    always_comb begin
        issue_left = r_rd_idx < r_len;
        rd_en      = r_active && issue_left && (!r_rd_pend || i_take);
        done       = r_active && !issue_left && (!r_rd_pend || i_take);
        if (rd_en) begin
            n_rd_pend = 1'b1;
        end else if (i_take) begin
            n_rd_pend = 1'b0;
        end else begin
            n_rd_pend = r_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_q     <= r_mem[r_rd_idx[AW-1:0]];
            r_q_idx <= r_rd_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_rd_pend <= 1'b0;
            r_rd_idx  <= '0;
            r_len     <= '0;
        end else if (i_ctl.start) begin
            r_active  <= 1'b1;
            r_rd_pend <= 1'b0;
            r_rd_idx  <= '0;
            r_len     <= i_ctl.len;
        end else begin
            r_rd_pend <= n_rd_pend;
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (done) begin
                r_active <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.busy  = r_active;
        o_stat.valid = r_rd_pend;
        o_stat.data  = r_q;
        o_stat.idx   = r_q_idx;
        o_stat.last  = ({1'b0, r_q_idx} + 7'd1) == r_len;
    end

endmodule

/* design/crc16_frame_deframer.sv */
// Frame deframer: start byte, type, LE length, payload, LE CRC-16/CCITT-FALSE.
// Intake takes one byte per cycle unless a drain or a busy output register holds it; a status
// result appears in the output register the cycle after its byte. A good frame of N > 0 bytes
// drains one byte a cycle while the output register is free, via a registered payload memory read;
// intake holds until the drain ends. Synchronous active-low reset returns to hunting, clears
// counters and restores the default configuration. Depends on cfd_pkg and cfd_drain.
`timescale 1ns / 1ps

module crc16_frame_deframer
    import cfd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] frame_type, [14:8] frame_length, [22:15] data_byte, [28:23] byte_index,
    // [44:29] crc_error_count, [60:45] oversize_count, [63:61] zero
    output logic [63:0] m_axis_tdata,
    // [1:0] status, [2] data_valid
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(PAYLOAD_DEPTH);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_LENLO = 3'd2;
    localparam logic [2:0] PH_LENHI = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRCLO = 3'd5;
    localparam logic [2:0] PH_CRCHI = 3'd6;

    // configuration
    logic [7:0]       r_start_byte;
    logic [LEN_W-1:0] r_max_len;

    // frame intake state
    logic [2:0]       r_phase,  n_phase;
    logic [7:0]       r_type,   n_type;
    logic [7:0]       r_len_lo, n_len_lo;
    logic [LEN_W-1:0] r_len,    n_len;
    logic [LEN_W-1:0] r_pos,    n_pos;
    logic [15:0]      r_crc,    n_crc;
    logic [7:0]       r_crc_lo, n_crc_lo;
    logic [15:0]      r_crc_errs, n_crc_errs;
    logic [15:0]      r_ovs_errs, n_ovs_errs;

    // output register
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [7:0]       r_out_type;
    logic [LEN_W-1:0] r_out_len;
    logic [7:0]       r_out_data;
    logic             r_out_dv;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_last;

    logic             in_xfer;
    logic             out_free;
    logic             res_phase;
    logic             res_load;      // intake produces a status result this cycle
    logic [1:0]       res_status;
    logic [LEN_W-1:0] res_len;
    logic             drain_load;
    logic [15:0]      full_len;
    logic [LEN_W-1:0] limit;
    logic [15:0]      crc_b;
    logic             wr_en;
    t_drain_ctl       drain_ctl;
    t_drain_stat      drain_stat;

    assign o_cfg_ready = 1'b1;

    // The user must write configuration only while idle; the block does not enforce it and takes it whenever offered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= 8'd170;
            r_max_len    <= 7'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_BYTE: r_start_byte <= i_cfg_data;
                CFG_MAX_LEN:    r_max_len    <= i_cfg_data[LEN_W-1:0];
                default:        r_start_byte <= r_start_byte;
            endcase
        end
    end

    // Hold intake while draining, and on a length-high or CRC-high byte, which can yield a result,
    // until the output register frees up.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign res_phase     = (r_phase == PH_LENHI) || (r_phase == PH_CRCHI);
    assign s_axis_tready = !drain_stat.busy && (!res_phase || out_free);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign full_len = {s_axis_tdata, r_len_lo};
    assign limit    = (r_max_len > DEPTH_LEN) ? DEPTH_LEN : r_max_len;
    assign crc_b    = crc16_step(r_crc, s_axis_tdata);
    assign wr_en    = in_xfer && (r_phase == PH_DATA) && (r_pos < DEPTH_LEN);

    always_comb begin
        n_phase    = r_phase;
        n_type     = r_type;
        n_len_lo   = r_len_lo;
        n_len      = r_len;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_crc_lo   = r_crc_lo;
        n_crc_errs = r_crc_errs;
        n_ovs_errs = r_ovs_errs;
        res_load   = 1'b0;
        res_status = STAT_GOOD;
        res_len    = r_len;
        drain_ctl.start = 1'b0;
        drain_ctl.len   = r_len;
        if (in_xfer) begin
            unique case (r_phase)
                PH_TYPE: begin
                    n_type  = s_axis_tdata;
                    n_crc   = crc_b;
                    n_phase = PH_LENLO;
                end
                PH_LENLO: begin
                    n_len_lo = s_axis_tdata;
                    n_crc    = crc_b;
                    n_phase  = PH_LENHI;
                end
                PH_LENHI: begin
                    n_crc = crc_b;
                    n_pos = '0;
                    if (full_len > {9'd0, limit}) begin
                        // oversize: report, count, drop the frame
                        if (r_ovs_errs != COUNT_MAX) begin
                            n_ovs_errs = r_ovs_errs + 16'd1;
                        end
                        res_load   = 1'b1;
                        res_status = STAT_OVERSIZE;
                        res_len    = (full_len > 16'd127) ? 7'd127 : full_len[LEN_W-1:0];
                        n_phase    = PH_HUNT;
                        n_crc      = CRC_INIT;
                    end else begin
                        n_len   = full_len[LEN_W-1:0];
                        n_phase = (full_len == 16'd0) ? PH_CRCLO : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_pos = r_pos + 1'b1;
                    n_crc = crc_b;
                    if (n_pos >= r_len) begin
                        n_phase = PH_CRCLO;
                    end
                end
                PH_CRCLO: begin
                    n_crc_lo = s_axis_tdata;
                    n_phase  = PH_CRCHI;
                end
                PH_CRCHI: begin
                    if ({s_axis_tdata, r_crc_lo} == r_crc) begin
                        if (r_len == '0) begin
                            res_load = 1'b1;
                        end else begin
                            drain_ctl.start = 1'b1;
                        end
                    end else begin
                        if (r_crc_errs != COUNT_MAX) begin
                            n_crc_errs = r_crc_errs + 16'd1;
                        end
                        res_load   = 1'b1;
                        res_status = STAT_CRC_ERR;
                    end
                    n_phase = PH_HUNT;
                    n_crc   = CRC_INIT;
                end
                default: begin
                    // hunting, and any unused code
                    if (s_axis_tdata == r_start_byte) begin
                        n_crc   = CRC_INIT;
                        n_phase = PH_TYPE;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_type     <= '0;
            r_len_lo   <= '0;
            r_len      <= '0;
            r_pos      <= '0;
            r_crc      <= CRC_INIT;
            r_crc_lo   <= '0;
            r_crc_errs <= '0;
            r_ovs_errs <= '0;
        end else begin
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_len_lo   <= n_len_lo;
            r_len      <= n_len;
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_crc_lo   <= n_crc_lo;
            r_crc_errs <= n_crc_errs;
            r_ovs_errs <= n_ovs_errs;
        end
    end

    cfd_drain #(
        .DEPTH (PAYLOAD_DEPTH)
    ) u_drain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pos[AW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_ctl     (drain_ctl),
        .i_take    (drain_load),
        .o_stat    (drain_stat)
    );

    // Advance the drain whenever its byte can move into the output register.
    assign drain_load = drain_stat.valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load || drain_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_status <= res_status;
            r_out_type   <= r_type;
            r_out_len    <= res_len;
            r_out_data   <= '0;
            r_out_dv     <= 1'b0;
            r_out_idx    <= '0;
            r_out_last   <= 1'b1;
        end else if (drain_load) begin
            r_out_status <= STAT_GOOD;
            r_out_type   <= r_type;
            r_out_len    <= r_len;
            r_out_data   <= drain_stat.data;
            r_out_dv     <= 1'b1;
            r_out_idx    <= drain_stat.idx;
            r_out_last   <= drain_stat.last;
        end
    end

    // Counters only change on a result load, which needs a free output register,
    // so their live values always match the result being shown.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_ovs_errs, r_crc_errs, r_out_idx, r_out_data,
                            r_out_len, r_out_type};
    assign m_axis_tuser  = {r_out_dv, r_out_status};
    assign m_axis_tlast  = r_out_last;

endmodule

/* design/cfd_checker.sv */
// Port-level checks for crc16_frame_deframer, bound to the top level.
// Depends on cfd_pkg for the status codes.
`timescale 1ns / 1ps

module cfd_checker
    import cfd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
        else $error("unused status code");

    a_data_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == STAT_GOOD)
        else $error("payload byte on a failed frame");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tlast)
        else $error("status result without last");

endmodule

bind crc16_frame_deframer cfd_checker u_cfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* dv/tb_crc16_frame_deframer.sv */
// Self-checking testbench for crc16_frame_deframer: drives received bytes and register
// writes, predicts every result transfer and compares it field by field.
// Depends on cfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_crc16_frame_deframer;
    import cfd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int PAYLOAD_DEPTH = 64;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int SETTLE_CYCLES = 8;     // quiet time before a register write
    localparam int END_CYCLES    = 80;    // covers a full 64-byte drain
    localparam int MAX_PRINTS    = 40;    // keep the log short on a broken build

    // Frame parser phases as the byte stream walks through a frame.
    typedef enum logic [2:0] {
        RX_HUNT, RX_TYPE, RX_LEN_LO, RX_LEN_HI, RX_DATA, RX_CRC_LO, RX_CRC_HI
    } t_rx_phase;

    // One result transfer as the block should present it.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  ftype;
        logic [6:0]  flen;
        logic [7:0]  dbyte;
        logic        dvalid;
        logic [5:0]  idx;
        logic        last;
        logic [15:0] crc_errs;
        logic [15:0] ovs_errs;
    } t_frame_result;

    // ------------------------------------------------------------------
    // Block ports; every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index   = 1'b0;
    logic [7:0]  i_cfg_data    = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    crc16_frame_deframer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the deframer: register copies and frame state, at the
    // values the block takes after reset.
    // ------------------------------------------------------------------
    logic [7:0]  cfg_start    = 8'd170;
    logic [6:0]  cfg_max_len  = 7'd64;
    t_rx_phase   rx_phase     = RX_HUNT;
    logic [7:0]  hold_type    = 8'h00;
    logic [15:0] want_len     = 16'h0000;
    logic [6:0]  pay_pos      = 7'd0;
    logic [15:0] crc_acc      = CRC_INIT;
    logic [7:0]  crc_low      = 8'h00;
    logic [7:0]  pay_mem [PAYLOAD_DEPTH];
    logic [15:0] crc_err_cnt  = 16'h0000;
    logic [15:0] ovs_err_cnt  = 16'h0000;

    t_frame_result expected_results [$];

    int send_idle_pct = 17;
    int recv_idle_pct = 66;
    int bytes_sent    = 0;
    int error_count   = 0;
    int stall_cycles  = 0;

    // Bit-serial CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // The store depth caps whatever the length register says.
    function automatic logic [6:0] eff_limit();
        return (cfg_max_len > 7'(PAYLOAD_DEPTH)) ? 7'(PAYLOAD_DEPTH) : cfg_max_len;
    endfunction

    function automatic void clear_frame();
        rx_phase  = RX_HUNT;
        hold_type = 8'h00;
        want_len  = 16'h0000;
        pay_pos   = 7'd0;
        crc_acc   = CRC_INIT;
        crc_low   = 8'h00;
    endfunction

    // Advance the shadow by one accepted byte and queue whatever results it causes.
    function automatic void absorb_rx_byte(input logic [7:0] b);
        t_frame_result r;
        r = '0;
        r.ftype = hold_type;
        case (rx_phase)
            RX_TYPE: begin
                hold_type = b;
                crc_acc   = crc_ccitt_byte(crc_acc, b);
                rx_phase  = RX_LEN_LO;
            end
            RX_LEN_LO: begin
                want_len = {8'h00, b};
                crc_acc  = crc_ccitt_byte(crc_acc, b);
                rx_phase = RX_LEN_HI;
            end
            RX_LEN_HI: begin
                want_len[15:8] = b;
                crc_acc        = crc_ccitt_byte(crc_acc, b);
                if (want_len > eff_limit()) begin
                    // oversize: one status result, length clamps at 127, back to hunting
                    if (ovs_err_cnt != COUNT_MAX) begin
                        ovs_err_cnt++;
                    end
                    r.status   = STAT_OVERSIZE;
                    r.flen     = (want_len > 16'd127) ? 7'd127 : want_len[6:0];
                    r.last     = 1'b1;
                    r.crc_errs = crc_err_cnt;
                    r.ovs_errs = ovs_err_cnt;
                    expected_results.push_back(r);
                    clear_frame();
                end else begin
                    pay_pos  = 7'd0;
                    rx_phase = (want_len == 16'd0) ? RX_CRC_LO : RX_DATA;
                end
            end
            RX_DATA: begin
                if (pay_pos < 7'(PAYLOAD_DEPTH)) begin
                    pay_mem[pay_pos[5:0]] = b;
                end
                pay_pos = pay_pos + 7'd1;
                crc_acc = crc_ccitt_byte(crc_acc, b);
                if (16'(pay_pos) >= want_len) begin
                    rx_phase = RX_CRC_LO;
                end
            end
            RX_CRC_LO: begin
                crc_low  = b;
                rx_phase = RX_CRC_HI;
            end
            RX_CRC_HI: begin
                r.crc_errs = crc_err_cnt;
                r.ovs_errs = ovs_err_cnt;
                r.flen     = want_len[6:0];
                if ({b, crc_low} == crc_acc) begin
                    if (want_len == 16'd0) begin
                        r.status = STAT_GOOD;
                        r.last   = 1'b1;
                        expected_results.push_back(r);
                    end else begin
                        // good frame: one transfer per stored byte, last on the final one
                        for (int i = 0; i < int'(want_len) && i < PAYLOAD_DEPTH; i++) begin
                            r.status = STAT_GOOD;
                            r.dbyte  = pay_mem[i];
                            r.dvalid = 1'b1;
                            r.idx    = 6'(i);
                            r.last   = (i + 1 == int'(want_len));
                            expected_results.push_back(r);
                        end
                    end
                end else begin
                    if (crc_err_cnt != COUNT_MAX) begin
                        crc_err_cnt++;
                    end
                    r.status   = STAT_CRC_ERR;
                    r.last     = 1'b1;
                    r.crc_errs = crc_err_cnt;
                    expected_results.push_back(r);
                end
                clear_frame();
            end
            default: begin
                // hunting: only the start byte opens a frame
                if (b == cfg_start) begin
                    crc_acc  = CRC_INIT;
                    rx_phase = RX_TYPE;
                end else begin
                    rx_phase = RX_HUNT;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting; printing stops after a while but counting goes on.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("@%0t %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            report_mismatch(name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure set at the falling edge, transfers
    // checked at the rising edge against the oldest expectation.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected", 64'd0, m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                check_field("status",          want.status,   m_axis_tuser[1:0]);
                check_field("data_valid",      want.dvalid,   m_axis_tuser[2]);
                check_field("frame_type",      want.ftype,    m_axis_tdata[7:0]);
                check_field("frame_length",    want.flen,     m_axis_tdata[14:8]);
                check_field("data_byte",       want.dbyte,    m_axis_tdata[22:15]);
                check_field("byte_index",      want.idx,      m_axis_tdata[28:23]);
                check_field("crc_error_count", want.crc_errs, m_axis_tdata[44:29]);
                check_field("oversize_count",  want.ovs_errs, m_axis_tdata[60:45]);
                check_field("tdata padding",   64'd0,         m_axis_tdata[63:61]);
                check_field("last",            want.last,     m_axis_tlast);
            end
        end
    end

    // Watchdog: end the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------

    // Send one received byte; idle the stream at random first, then hold
    // tvalid until the transfer happens.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        absorb_rx_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Drop tvalid, wait for every expected transfer, then let the block go quiet.
    task automatic wait_quiet(input int extra_cycles);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (extra_cycles) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Finish any half-received frame with filler, go quiet, then write the register.
    task automatic set_reg(input logic idx, input logic [7:0] val);
        while (rx_phase != RX_HUNT) begin
            push_byte(8'($urandom_range(255)));
        end
        wait_quiet(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx == CFG_START_BYTE) begin
            cfg_start = val;
        end else begin
            cfg_max_len = val[6:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Build a frame on the wire: start, type, LE length, payload, LE CRC. An
    // oversize length stops after the header. A nonnegative cut sends only
    // that many leading bytes.
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len_field,
                              input bit corrupt, input bit alt_bytes, input int cut);
        logic [7:0]  frame_q [$];
        logic [15:0] crc;
        logic [7:0]  pb;
        frame_q = {cfg_start, ftype, len_field[7:0], len_field[15:8]};
        crc     = CRC_INIT;
        for (int i = 1; i < 4; i++) begin
            crc = crc_ccitt_byte(crc, frame_q[i]);
        end
        if (len_field <= 16'(eff_limit())) begin
            for (int i = 0; i < int'(len_field); i++) begin
                pb = alt_bytes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(255));
                frame_q.push_back(pb);
                crc = crc_ccitt_byte(crc, pb);
            end
            if (corrupt) begin
                crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
            end
            frame_q.push_back(crc[7:0]);
            frame_q.push_back(crc[15:8]);
        end
        foreach (frame_q[i]) begin
            if (cut < 0 || i < cut) begin
                push_byte(frame_q[i]);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Good, empty, corrupted and oversize frames under the reset settings.
    task automatic test_frame_kinds();
        push_byte(8'h00);                                   // ignored while hunting
        push_byte(8'hFF);
        send_frame(8'hFF, 16'd0, 1'b0, 1'b0, -1);           // empty good frame
        send_frame(8'h00, 16'd2, 1'b0, 1'b1, -1);           // payload 00 FF
        send_frame(8'h3C, 16'd0, 1'b1, 1'b0, -1);           // crc mismatch
        send_frame(8'hC3, 16'hFFFF, 1'b0, 1'b0, -1);        // oversize, length clamps
    endtask

    // Length register at zero, above the store depth, and back at the top.
    task automatic test_length_limits();
        set_reg(CFG_MAX_LEN, 8'd0);
        send_frame(8'h11, 16'd1, 1'b0, 1'b0, -1);           // anything nonzero is oversize
        send_frame(8'h22, 16'd0, 1'b0, 1'b0, -1);
        set_reg(CFG_MAX_LEN, 8'd127);                       // store depth caps the limit
        send_frame(8'h33, 16'd65, 1'b0, 1'b0, -1);
        send_frame(8'h44, 16'd64, 1'b0, 1'b1, -1);          // fullest frame
        send_frame(8'h55, 16'h0100, 1'b0, 1'b0, -1);        // high length byte alone
        set_reg(CFG_MAX_LEN, 8'd64);
        send_frame(8'h66, 16'd64, 1'b1, 1'b0, -1);
    endtask

    // Start byte at both ends of its range; the old one must no longer open a frame.
    task automatic test_start_byte_values();
        set_reg(CFG_START_BYTE, 8'h00);
        push_byte(8'd170);
        send_frame(8'h5A, 16'd1, 1'b0, 1'b0, -1);
        set_reg(CFG_START_BYTE, 8'hFF);
        push_byte(8'h00);
        send_frame(8'hA5, 16'd3, 1'b0, 1'b0, -1);
    endtask

    // Mostly well-formed frames with random content, plus truncated frames,
    // oversize headers and line noise.
    task automatic test_random_traffic(input int n_bytes);
        int         stop_at;
        int         pick;
        logic [6:0] lim;
        logic [15:0] len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            lim  = eff_limit();
            pick = $urandom_range(99);
            if (pick < 75) begin
                // keep most payloads short so frames stay cheap
                if ($urandom_range(3) != 0) begin
                    len = 16'($urandom_range(0, (lim < 7'd8) ? lim : 7'd8));
                end else begin
                    len = 16'($urandom_range(0, lim));
                end
                send_frame(8'($urandom_range(255)), len, pick >= 58, 1'b0,
                           (pick >= 70) ? int'($urandom_range(1, int'(len) + 5)) : -1);
            end else if (pick < 87) begin
                if ($urandom_range(1) != 0) begin
                    len = 16'($urandom_range(int'(lim) + 1, 127));
                end else begin
                    len = 16'($urandom_range(int'(lim) + 1, 16'hFFFF));
                end
                send_frame(8'($urandom_range(255)), len, 1'b0, 1'b0, -1);
            end else begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // hold reset, then release it at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender idles lightly, receiver stalls heavily
        send_idle_pct = 17;
        recv_idle_pct = 66;
        test_frame_kinds();
        test_length_limits();
        test_start_byte_values();
        set_reg(CFG_START_BYTE, 8'($urandom_range(255)));
        test_random_traffic(70);

        // roles swapped, with a tighter random length limit
        send_idle_pct = 66;
        recv_idle_pct = 17;
        set_reg(CFG_START_BYTE, 8'($urandom_range(255)));
        set_reg(CFG_MAX_LEN, 8'($urandom_range(1, 63)));
        test_random_traffic(75);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_reg(CFG_START_BYTE, 8'd170);
        set_reg(CFG_MAX_LEN, 8'd127);
        test_random_traffic(75);

        wait_quiet(END_CYCLES);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
design/cfd_pkg.sv
design/cfd_drain.sv
design/crc16_frame_deframer.sv
design/cfd_checker.sv
dv/tb_crc16_frame_deframer.sv
